@@ design/ptul_pkg.sv @@
// Shared types and constants for the placement table update/lookup stage.
// No dependencies; imported by placement_table_update_lookup.
`default_nettype none
package ptul_pkg;

  localparam int unsigned NODE_W  = 8;
  localparam int unsigned LANES   = 4;
  localparam int unsigned LANE_W  = LANES * NODE_W;
  localparam int unsigned WORD_W  = 24;
  localparam int unsigned SWAP_W  = 10;
  localparam int unsigned THR_W   = 2;
  localparam int unsigned CAND_W  = 5;

  localparam logic [NODE_W-1:0] NO_CELL = '1;  // -1

  typedef enum logic {
    REQ_PIPE = 1'b0,
    REQ_LOAD = 1'b1
  } req_t;

  // table write word: thread, cell, signed node
  typedef struct packed {
    logic [NODE_W-1:0] thread;
    logic [NODE_W-1:0] cell_id;
    logic [NODE_W-1:0] node;
  } write_t;

endpackage
`default_nettype wire

@@ design/placement_table_update_lookup.sv @@
// Top level of the placement table update/lookup stage.
// Depends on ptul_pkg and ptul_ram.
`default_nettype none
// Accepts one transaction per cycle and delivers its result through stage 1 and
// an output register, so back-to-back traffic flows at full rate while the
// output side keeps taking results. The node-to-cell table lives in one RAM
// with one row per thread (CELLS bytes a row): each transaction reads the row its
// table write targets on one read port and the row its own thread uses on the
// other, merges the write in the next cycle and writes the row back. The row just
// written is held in a forwarding register for the transaction read in the same
// cycle. Table contents are undefined until loaded; a load request (req_type 1)
// writes one entry from late_write_b and returns all-ones cell lanes.
module placement_table_update_lookup #(
  parameter int unsigned THREADS = 4,
  parameter int unsigned CELLS   = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           req_type,
  input  wire logic [ptul_pkg::THR_W-1:0]     thread_id,
  input  wire logic                           thread_valid,
  input  wire logic signed [ptul_pkg::CAND_W-1:0] cell_first,
  input  wire logic signed [ptul_pkg::CAND_W-1:0] cell_second,
  input  wire logic [ptul_pkg::LANE_W-1:0]    neighbours_a,
  input  wire logic [ptul_pkg::LANE_W-1:0]    neighbours_b,
  input  wire logic [ptul_pkg::SWAP_W-1:0]    swap_info,
  input  wire logic [ptul_pkg::WORD_W-1:0]    write_a,
  input  wire logic [ptul_pkg::WORD_W-1:0]    write_b,
  input  wire logic [ptul_pkg::WORD_W-1:0]    late_write_b,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ptul_pkg::THR_W-1:0]          out_thread_id,
  output logic                                out_thread_valid,
  output logic signed [ptul_pkg::CAND_W-1:0]  out_cell_first,
  output logic signed [ptul_pkg::CAND_W-1:0]  out_cell_second,
  output logic [ptul_pkg::LANE_W-1:0]         cells_a,
  output logic [ptul_pkg::LANE_W-1:0]         cells_b,
  output logic [ptul_pkg::SWAP_W-1:0]         out_swap_info,
  output logic [ptul_pkg::WORD_W-1:0]         out_write_a,
  output logic [ptul_pkg::WORD_W-1:0]         out_write_b
);

  import ptul_pkg::*;

  localparam int unsigned TW    = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int unsigned NW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned ROW_W = CELLS * NODE_W;

  typedef logic [CELLS-1:0][NODE_W-1:0] row_t;

  // control state
  logic take_first_write;
  logic prev_swap;
  logic [WORD_W-1:0] prev_write_a;
  logic s1_valid;
  logic fwd_valid;

  // stage 1 payload
  req_t                     s1_req;
  logic [THR_W-1:0]         s1_thread_id;
  logic                     s1_thr_ok;
  logic [TW-1:0]            s1_thr;
  logic                     s1_thread_valid;
  logic [CAND_W-1:0]        s1_cell_first;
  logic [CAND_W-1:0]        s1_cell_second;
  logic [LANE_W-1:0]        s1_nb_a;
  logic [LANE_W-1:0]        s1_nb_b;
  logic [SWAP_W-1:0]        s1_swap_info;
  logic [WORD_W-1:0]        s1_write_a;
  logic [WORD_W-1:0]        s1_write_b;
  logic                     s1_wr_en;
  logic [TW-1:0]            s1_wr_row;
  logic [NW-1:0]            s1_wr_node;
  logic [NODE_W-1:0]        s1_wr_cell;

  // forwarding of the last row written
  logic [TW-1:0] fwd_row;
  row_t          fwd_data;

  logic in_accept;
  logic s1_adv;
  logic wr_fire;

  write_t        wr_word;
  logic          wr_sel;
  logic          wr_ok;
  logic [TW-1:0] rd_thr;
  logic          thr_ok;

  logic [ROW_W-1:0] rdata_a;
  logic [ROW_W-1:0] rdata_b;
  row_t row_wr;
  row_t row_look_raw;
  row_t row_merged;
  row_t row_look;
  logic [LANE_W-1:0] look_a;
  logic [LANE_W-1:0] look_b;

  assign s1_adv    = !out_valid || out_ready;
  assign in_ready  = !s1_valid || s1_adv;
  assign in_accept = in_valid && in_ready;
  assign wr_fire   = s1_valid && s1_adv && s1_wr_en;

  // pick this transaction's table write
  always_comb begin
    wr_sel  = 1'b0;
    wr_word = write_t'(late_write_b);
    case (req_t'(req_type))
      REQ_LOAD: begin
        wr_sel = 1'b1;
      end
      REQ_PIPE: begin
        wr_sel = prev_swap;
        if (take_first_write) begin
          wr_word = write_t'(prev_write_a);
        end
      end
      default: begin
        wr_sel = 1'b0;
      end
    endcase
    wr_ok = wr_sel && !wr_word.node[NODE_W-1]
            && (32'(wr_word.node) < CELLS) && (32'(wr_word.thread) < THREADS);
    rd_thr = TW'(thread_id);
    thr_ok = 32'(thread_id) < THREADS;
  end

  ptul_ram #(
    .WIDTH(ROW_W),
    .DEPTH(THREADS)
  ) u_table (
    .clk    (clk),
    .we     (wr_fire),
    .waddr  (s1_wr_row),
    .wdata  (row_merged),
    .re     (in_accept),
    .raddr_a(wr_word.thread[TW-1:0]),
    .raddr_b(rd_thr),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  // history and stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      take_first_write <= 1'b1;
      prev_swap        <= 1'b0;
      prev_write_a     <= '0;
      s1_valid         <= 1'b0;
    end else begin
      if (in_accept && req_t'(req_type) == REQ_PIPE) begin
        if (prev_swap) begin
          take_first_write <= !take_first_write;
        end
        prev_swap    <= swap_info[0];
        prev_write_a <= write_a;
      end
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req          <= req_t'(req_type);
      s1_thread_id    <= thread_id;
      s1_thr_ok       <= thr_ok;
      s1_thr          <= rd_thr;
      s1_thread_valid <= thread_valid;
      s1_cell_first   <= cell_first;
      s1_cell_second  <= cell_second;
      s1_nb_a         <= neighbours_a;
      s1_nb_b         <= neighbours_b;
      s1_swap_info    <= swap_info;
      s1_write_a      <= write_a;
      s1_write_b      <= write_b;
      s1_wr_en        <= wr_ok;
      s1_wr_row       <= wr_word.thread[TW-1:0];
      s1_wr_node      <= wr_word.node[NW-1:0];
      s1_wr_cell      <= wr_word.cell_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr_fire) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      fwd_row  <= s1_wr_row;
      fwd_data <= row_merged;
    end
  end

  // read-modify-write of the row; lookups see this transaction's write
  always_comb begin
    row_wr = row_t'(rdata_a);
    if (fwd_valid && fwd_row == s1_wr_row) begin
      row_wr = fwd_data;
    end
    row_look_raw = row_t'(rdata_b);
    if (fwd_valid && fwd_row == s1_thr) begin
      row_look_raw = fwd_data;
    end
    row_merged = row_wr;
    row_merged[s1_wr_node] = s1_wr_cell;
    row_look = row_look_raw;
    if (s1_wr_en && s1_wr_row == s1_thr) begin
      row_look = row_merged;
    end
  end

  always_comb begin
    logic [NODE_W-1:0] na;
    logic [NODE_W-1:0] nb;
    look_a = '0;
    look_b = '0;
    for (int n = 0; n < LANES; n++) begin
      na = s1_nb_a[n*NODE_W +: NODE_W];
      nb = s1_nb_b[n*NODE_W +: NODE_W];
      look_a[n*NODE_W +: NODE_W] =
        (s1_thr_ok && !na[NODE_W-1] && 32'(na) < CELLS) ? row_look[na[NW-1:0]] : NO_CELL;
      look_b[n*NODE_W +: NODE_W] =
        (s1_thr_ok && !nb[NODE_W-1] && 32'(nb) < CELLS) ? row_look[nb[NW-1:0]] : NO_CELL;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      out_thread_id <= s1_thread_id;
      if (s1_req == REQ_LOAD) begin
        out_thread_valid <= 1'b0;
        out_cell_first   <= '0;
        out_cell_second  <= '0;
        cells_a          <= '1;
        cells_b          <= '1;
        out_swap_info    <= '0;
        out_write_a      <= '0;
        out_write_b      <= '0;
      end else begin
        out_thread_valid <= s1_thread_valid;
        out_cell_first   <= s1_cell_first;
        out_cell_second  <= s1_cell_second;
        cells_a          <= look_a;
        cells_b          <= look_b;
        out_swap_info    <= s1_swap_info;
        out_write_a      <= s1_write_a;
        out_write_b      <= s1_write_b;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/ptul_ram.sv @@
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none
module ptul_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic      [WIDTH-1:0]                      rdata_a,
  output logic      [WIDTH-1:0]                      rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire
